[hdl/dowjg_pkg.sv]
// Shared types, constants and month tables for the weekday pipeline.
package dowjg_pkg;

  localparam int unsigned YearW = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW = 5;
  localparam int unsigned WdayW = 3;

  localparam logic [YearW-1:0] SwitchYear = 14'd1752;
  localparam logic [YearW-1:0] MaxYear = 14'd9999;
  localparam logic [MonthW-1:0] MonthSep = 4'd9;
  localparam logic [DayW-1:0] LastJulianDay = 5'd2;
  localparam logic [DayW-1:0] FirstGregDay = 5'd14;

  // floor(y / 100) == (y * Recip100) >> Recip100Shift for every 14-bit y
  localparam int unsigned ProdW = 27;
  localparam logic [ProdW-1:0] Recip100 = 27'd5243;
  localparam int unsigned Recip100Shift = 19;
  localparam int unsigned Q100W = 8;

  // day sums stay below 2^15
  localparam int unsigned SumW = 15;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } in_word_t;

  typedef struct packed {
    logic             valid_res;
    logic [WdayW-1:0] weekday;
  } out_word_t;

  // days in month, common year; 0 for codes outside 1..12
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2: len = 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // weekday offset of the first of each month
  function automatic logic [WdayW-1:0] month_off(input logic [MonthW-1:0] m);
    logic [WdayW-1:0] off;
    case (m)
      4'd1: off = 3'd0;
      4'd2: off = 3'd3;
      4'd3: off = 3'd2;
      4'd4: off = 3'd5;
      4'd5: off = 3'd0;
      4'd6: off = 3'd3;
      4'd7: off = 3'd5;
      4'd8: off = 3'd1;
      4'd9: off = 3'd4;
      4'd10: off = 3'd6;
      4'd11: off = 3'd2;
      4'd12: off = 3'd4;
      default: off = 3'd0;
    endcase
    return off;
  endfunction

endpackage

[hdl/day_of_week_julian_gregorian_top.sv]
// Top level: three-stage weekday pipeline with the 1752 calendar switch.
//
// Usage
//   Input channel carries one date word (year, month, day) per accepted
//   cycle: in_valid_i high and in_stall_o low. Output channel carries one
//   result word (valid_res, weekday) per date, accepted when out_valid_o
//   is high and out_stall_i low. Results leave in input order.
// Pipeline
//   An accepted date passes the stage 1, stage 2 and output registers in
//   order. One date per cycle while in_stall_o is low; three register stages:
//   reciprocal multiply for /100, day-count sum, then mod-7 fold.
// Stall
//   The stages move together. When a result waits at the output under
//   out_stall_i, the whole pipe holds and in_stall_o rises; bubbles
//   never block input, so an empty output stage keeps in_stall_o low.
// Reset
//   rst_ni (async, active low) clears all stage valid bits; data
//   registers are not reset.
// Invalid dates (bad month, day 0, day past month end, year above 9999,
// 3..13 September 1752) come out with valid_res 0 and weekday 0.
module day_of_week_julian_gregorian_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  dowjg_pkg::in_word_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output dowjg_pkg::out_word_t out_data_o
);
  import dowjg_pkg::*;

  // global advance: hold only when a result sits unread at the output
  logic adv;
  assign adv = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // ---------------- stage 1: checks, borrow, /100 product ----------------
  logic              s1_v_q;
  logic [YearW-1:0]  s1_year_q;
  logic [MonthW-1:0] s1_month_q;
  logic [DayW-1:0]   s1_day_q;
  logic              s1_borrow_q;   // Jan/Feb count from the previous year
  logic              s1_range_ok_q;
  logic              s1_julian_q;
  logic              s1_gap_q;
  logic [ProdW-1:0]  s1_prod_q;

  logic s1_range_ok_d, s1_julian_d, s1_gap_d, is_sw_year;

  always_comb begin
    is_sw_year = (in_data_i.year == SwitchYear);
    s1_range_ok_d = (in_data_i.year <= MaxYear) && (in_data_i.month != '0) &&
                    (in_data_i.month <= 4'd12) && (in_data_i.day != '0);
    s1_julian_d = (in_data_i.year < SwitchYear) ||
                  (is_sw_year && ((in_data_i.month < MonthSep) ||
                   ((in_data_i.month == MonthSep) && (in_data_i.day <= LastJulianDay))));
    s1_gap_d = is_sw_year && (in_data_i.month == MonthSep) &&
               (in_data_i.day > LastJulianDay) && (in_data_i.day < FirstGregDay);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_year_q     <= in_data_i.year;
      s1_month_q    <= in_data_i.month;
      s1_day_q      <= in_data_i.day;
      s1_borrow_q   <= (in_data_i.month < 4'd3);
      s1_range_ok_q <= s1_range_ok_d;
      s1_julian_q   <= s1_julian_d;
      s1_gap_q      <= s1_gap_d;
      s1_prod_q     <= ProdW'(in_data_i.year) * Recip100;
    end
  end

  // ---------------- stage 2: leap, length check, day sum ----------------
  logic            s2_v_q;
  logic            s2_ok_q;
  logic [SumW-1:0] s2_sum_q;

  logic [Q100W-1:0] q100, qg;
  logic             zero100, leap;
  logic [DayW:0]    len;
  logic [SumW-1:0]  yy_j, yy_g, sum_j, sum_g, off_w, day_w;
  logic             s2_ok_d;

  always_comb begin
    q100 = s1_prod_q[Recip100Shift +: Q100W];
    zero100 = ({1'b0, s1_year_q} == (SumW'(q100) * SumW'(100)));
    leap = (s1_year_q[1:0] == 2'b00) &&
           ((s1_year_q < SwitchYear) || !zero100 || (q100[1:0] == 2'b00));
    len = {1'b0, month_len(s1_month_q)} +
          (DayW+1)'((s1_month_q == 4'd2) && leap);
    s2_ok_d = s1_range_ok_q && !s1_gap_q && ({1'b0, s1_day_q} <= len);

    off_w = SumW'(month_off(s1_month_q));
    day_w = SumW'(s1_day_q);

    // Julian: 28 years added keeps the count non-negative for year 0
    yy_j = SumW'(s1_year_q) + SumW'(28) - SumW'(s1_borrow_q);
    sum_j = yy_j + (yy_j >> 2) + off_w + day_w + SumW'(5);

    // Gregorian: floor((y-b)/100) drops by one only at a century year
    yy_g = SumW'(s1_year_q) - SumW'(s1_borrow_q);
    qg = q100 - Q100W'(s1_borrow_q && zero100);
    sum_g = yy_g + (yy_g >> 2) + SumW'(qg >> 2) - SumW'(qg) + off_w + day_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_ok_q  <= s2_ok_d;
      s2_sum_q <= s1_julian_q ? sum_j : sum_g;
    end
  end

  // ---------------- stage 3: mod 7 and output register ----------------
  // 8 == 1 mod 7, so summing octal digits preserves the residue
  logic      out_v_q;
  out_word_t out_q;

  logic [5:0]       fold1;
  logic [3:0]       fold2;
  logic [WdayW-1:0] fold3, wd;

  always_comb begin
    fold1 = 6'(s2_sum_q[2:0]) + 6'(s2_sum_q[5:3]) + 6'(s2_sum_q[8:6]) +
            6'(s2_sum_q[11:9]) + 6'(s2_sum_q[14:12]);
    fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
    fold3 = fold2[2:0] + WdayW'(fold2[3]);
    wd = (fold3 == 3'd7) ? 3'd0 : fold3;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.valid_res <= s2_ok_q;
      out_q.weekday   <= s2_ok_q ? wd : '0;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

[hdl/dowjg_checker.sv]
// Port-level checker for the weekday pipeline, with its bind.
module dowjg_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input dowjg_pkg::out_word_t out_data_o
);
  import dowjg_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed under stall");

  // input backpressure comes only from a stalled, full output
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // invalid dates report weekday zero
  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.valid_res |-> out_data_o.weekday == '0)
    else $error("invalid date with nonzero weekday");

  // weekday code stays in 0..6
  a_wd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.weekday != 3'd7)
    else $error("weekday out of range");

  // an accepted date with a free output reaches out_valid_o through the pipeline
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
    |=> out_valid_o)
    else $error("result missing after pipeline latency");

endmodule

bind day_of_week_julian_gregorian_top dowjg_checker u_dowjg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the weekday pipeline with the 1752 calendar switch.
module tb;
  import dowjg_pkg::*;

  localparam int IdlePct = 24;
  localparam int DrainCycles = 8;

  // calendar constants held by the predictor
  localparam int CutoverYear = 1752;
  localparam int CutoverMonth = 9;
  localparam int LastOldDay = 2;
  localparam int FirstNewDay = 14;
  localparam int TopYear = 9999;
  localparam int FirstShift[12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  bit        idle_en = 1'b1;
  out_word_t weekday_q[$];
  int        n_err = 0;
  int        n_sent = 0;
  int        n_checked = 0;
  int        n_real_dates = 0;

  day_of_week_julian_gregorian_top u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------
  function automatic bit leap_year(input int y);
    if (y % 4 != 0) return 1'b0;
    if (y < CutoverYear) return 1'b1;
    if (y % 100 != 0) return 1'b1;
    return (y % 400) == 0;
  endfunction

  function automatic int month_days(input int y, input int m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11: return 30;
      2: return leap_year(y) ? 29 : 28;
      default: return 0;
    endcase
  endfunction

  function automatic out_word_t predict_weekday(input in_word_t w);
    int y, m, d, yy, wd;
    bit julian;
    out_word_t r;
    y = int'(w.year);
    m = int'(w.month);
    d = int'(w.day);
    r = '0;
    if (y > TopYear || m < 1 || m > 12 || d == 0) return r;
    if (d > month_days(y, m)) return r;
    // pick the calendar; the eleven dropped September days have none
    if (y != CutoverYear) julian = (y < CutoverYear);
    else if (m != CutoverMonth) julian = (m < CutoverMonth);
    else if (d <= LastOldDay) julian = 1'b1;
    else if (d >= FirstNewDay) julian = 1'b0;
    else return r;
    // Jan/Feb count as the tail of the previous year
    yy = y - ((m < 3) ? 1 : 0);
    if (julian) begin
      yy = yy + 28;  // keeps year zero positive, 28 years is whole weeks
      wd = (yy + yy / 4 + FirstShift[m-1] + d + 5) % 7;
    end else begin
      wd = (yy + yy / 4 - yy / 100 + yy / 400 + FirstShift[m-1] + d) % 7;
    end
    r.valid_res = 1'b1;
    r.weekday = wd[WdayW-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic in_word_t mk(input int y, input int m, input int d);
    in_word_t w;
    w.year = y[YearW-1:0];
    w.month = m[MonthW-1:0];
    w.day = d[DayW-1:0];
    return w;
  endfunction

  // well-formed date with year in [lo, hi]; may land in the 1752 gap
  function automatic in_word_t rand_date(input int lo, input int hi);
    int y, m;
    y = $urandom_range(hi, lo);
    m = $urandom_range(12, 1);
    return mk(y, m, $urandom_range(month_days(y, m), 1));
  endfunction

  function automatic in_word_t rand_noise();
    return in_word_t'((YearW + MonthW + DayW)'($urandom));
  endfunction

  // Entered at a falling edge; leaves at the falling edge after acceptance.
  task automatic send_date(input in_word_t w);
    // idle cycles drawn one at a time, about IdlePct of all cycles
    while (idle_en && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    weekday_q.push_back(predict_weekday(w));
    n_sent++;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    send_date(mk(0, 1, 1));        // year zero, Julian
    send_date(mk(0, 2, 29));       // year zero is leap
    send_date(mk(1, 1, 1));
    send_date(mk(1700, 2, 29));    // Julian leap century
    send_date(mk(1752, 2, 29));
    send_date(mk(1752, 8, 31));
    send_date(mk(1752, 9, 2));     // last Julian day
    send_date(mk(1752, 9, 3));     // gap start
    send_date(mk(1752, 9, 13));    // gap end
    send_date(mk(1752, 9, 14));    // first Gregorian day
    send_date(mk(1752, 10, 1));    // late 1752 uses Gregorian
    send_date(mk(1752, 12, 31));
    send_date(mk(1800, 2, 29));    // Gregorian common century
    send_date(mk(1900, 2, 29));
    send_date(mk(2000, 2, 29));    // divisible by 400
    send_date(mk(2023, 2, 29));
    send_date(mk(2024, 4, 31));    // past month end
    send_date(mk(2024, 1, 31));
    send_date(mk(2024, 0, 10));    // month zero
    send_date(mk(2024, 13, 1));
    send_date(mk(2024, 6, 0));     // day zero
    send_date(mk(5461, 10, 21));   // alternating year bits
    send_date(mk(9999, 12, 31));   // top year
    send_date(mk(10000, 1, 1));    // year out of range
    send_date(mk(16383, 15, 31));  // all ones
  endtask

  task automatic test_random_dates(input int n);
    repeat (n) begin
      if ($urandom_range(99) < 80) send_date(rand_date(0, TopYear));
      else send_date(rand_noise());
    end
  endtask

  // dates around the cutover and leap days of century years
  task automatic test_calendar_switch(input int n);
    repeat (n) begin
      case ($urandom_range(3))
        0: send_date(rand_date(CutoverYear, CutoverYear));
        1: send_date(mk(CutoverYear, CutoverMonth, $urandom_range(31, 0)));
        2: send_date(mk(100 * $urandom_range(99, 0), 2, $urandom_range(31, 27)));
        default: send_date(rand_date(CutoverYear - 12, CutoverYear + 12));
      endcase
    end
  endtask

  // full rate on both sides
  task automatic test_back_to_back(input int n);
    idle_en = 1'b0;
    repeat (n) begin
      if ($urandom_range(99) < 85) send_date(rand_date(0, TopYear));
      else send_date(rand_noise());
    end
    idle_en = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall, result check
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= idle_en && ($urandom_range(99) < IdlePct);
  end

  always @(posedge clk) begin : chk
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (weekday_q.size() == 0) begin
        $display("%0t: result word with nothing expected: valid_res=%0b weekday=%0d",
                 $time, out_data.valid_res, out_data.weekday);
        n_err++;
      end else begin
        want = weekday_q.pop_front();
        n_checked++;
        if (want.valid_res) n_real_dates++;
        if (out_data.valid_res !== want.valid_res) begin
          $display("%0t: valid_res expected %0b actual %0b",
                   $time, want.valid_res, out_data.valid_res);
          n_err++;
        end
        if (out_data.weekday !== want.weekday) begin
          $display("%0t: weekday expected %0d actual %0d",
                   $time, want.weekday, out_data.weekday);
          n_err++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_random_dates(400);
    test_calendar_switch(150);
    test_back_to_back(220);
    in_valid <= 1'b0;

    while (weekday_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d date words, checked %0d result words (%0d real dates).",
             n_sent, n_checked, n_real_dates);
    $display("Covered Julian, cutover gap, Gregorian, bad fields, idle and full rate.");
    if (n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Timed out with %0d result words outstanding.", weekday_q.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
